>>> hw/rtl/svie_pkg.sv
// Shared constants, types and helper functions of the scalar and vector instruction executor.
package svie_pkg;

    localparam int SCALAR_COUNT  = 256;
    localparam int VECTOR_COUNT  = 32;
    localparam int VECTOR_LANES  = 8;
    localparam int PROGRAM_BYTES = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam int SIDX_W = $clog2(SCALAR_COUNT);
    localparam int VIDX_W = $clog2(VECTOR_COUNT);
    localparam int LANE_W = $clog2(VECTOR_LANES);
    localparam int PC_W   = 11;
    localparam int CNT_W  = 4;

    localparam logic [7:0] OPC_HALT    = 8'h00;
    localparam logic [7:0] OPC_BRANCH  = 8'h10;
    localparam logic [7:0] OPC_BRANCH2 = 8'h1E;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_PRINT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_sel_t;

    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_HALT,
        CLS_BRANCH,
        CLS_ALU,
        CLS_DIV,
        CLS_LOAD,
        CLS_STORE,
        CLS_MOVE,
        CLS_PRINT,
        CLS_VALU,
        CLS_VLOAD,
        CLS_VSTORE
    } cls_t;

    typedef struct packed {
        logic        is_data;
        cls_t        cls;
        alu_sel_t    alu_sel;
        logic        use_imm;
        logic [7:0]  dest;
        logic [7:0]  src1;
        logic [7:0]  src2;
        logic [31:0] load_data;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_DIV,
        ST_LREQ,
        ST_VRD,
        ST_VEX,
        ST_STATUS
    } state_t;

    function automatic logic [31:0] alu_op(alu_sel_t sel, logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        case (sel)
            ALU_ADD: r = a + b;
            ALU_SUB: r = a - b;
            default: r = a * b;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/svie_front.sv
// Front end: accepts input words and classifies instructions before queuing them.
module svie_front
    import svie_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // opcode, dest_index, first_source, second_source, load_data
    input  logic        s_tuser,   // op
    input  logic        q_full,
    output logic        push,
    output item_t       item
);

    logic [7:0] opc;

    assign opc      = s_tdata[7:0];
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        item.is_data   = s_tuser;
        item.dest      = s_tdata[15:8];
        item.src1      = s_tdata[23:16];
        item.src2      = s_tdata[31:24];
        item.load_data = s_tdata[63:32];
        item.alu_sel   = alu_sel_t'(opc[1:0] - 2'd1);
        item.use_imm   = 1'b0;
        unique case (opc) inside
            OPC_HALT:                      item.cls = CLS_HALT;
            OPC_BRANCH, OPC_BRANCH2:       item.cls = CLS_BRANCH;
            8'h01, 8'h02, 8'h03:           item.cls = CLS_ALU;
            8'h09, 8'h0A, 8'h0B:
            begin
                item.cls     = CLS_ALU;
                item.use_imm = 1'b1;
            end
            8'h04:                         item.cls = CLS_DIV;
            8'h0C:
            begin
                item.cls     = CLS_DIV;
                item.use_imm = 1'b1;
            end
            8'h05:                         item.cls = CLS_LOAD;
            8'h0D:
            begin
                item.cls     = CLS_LOAD;
                item.use_imm = 1'b1;
            end
            8'h06:                         item.cls = CLS_STORE;
            8'h0E:
            begin
                item.cls     = CLS_STORE;
                item.use_imm = 1'b1;
            end
            8'h07:                         item.cls = CLS_MOVE;
            8'h0F:
            begin
                item.cls     = CLS_MOVE;
                item.use_imm = 1'b1;
            end
            8'h08:                         item.cls = CLS_PRINT;
            8'h21, 8'h22, 8'h23:           item.cls = CLS_VALU;
            8'h29, 8'h2A, 8'h2B:
            begin
                item.cls     = CLS_VALU;
                item.use_imm = 1'b1;
            end
            8'h25:                         item.cls = CLS_VLOAD;
            8'h2C:
            begin
                item.cls     = CLS_VLOAD;
                item.use_imm = 1'b1;
            end
            8'h26:                         item.cls = CLS_VSTORE;
            8'h2E:
            begin
                item.cls     = CLS_VSTORE;
                item.use_imm = 1'b1;
            end
            default:                       item.cls = CLS_NOP;
        endcase
    end

endmodule

>>> hw/rtl/svie_queue.sv
// Short queue of classified words between the front end and the execution back end.
module svie_queue
    import svie_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_pop;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign do_pop   = pop && valid;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/svie_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module svie_div
    import svie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] ub_reg, ub_next;
    logic        neg_reg, neg_next;
    logic [33:0] trial;

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign trial    = {1'b0, rem_reg, quo_reg[31]} - {2'b00, ub_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            ub_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            // Restoring step: keep the difference when it does not go negative.
            if (!trial[33])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
    end

endmodule

>>> hw/rtl/svie_back.sv
// Back end: architectural state, register files and the execution sequencer.
module svie_back
    import svie_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  item_t        q_item,
    output logic         q_pop,
    output logic         div_start,
    output logic [31:0]  div_a,
    output logic [31:0]  div_b,
    input  logic         div_done,
    input  logic [31:0]  div_q,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // address, data, print_index, next_pc, halted, zero pad
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast
);

    localparam int VADDR_W = VIDX_W + LANE_W;
    localparam int VDEPTH  = VECTOR_COUNT * VECTOR_LANES;

    // Register files with a valid bit per entry so that reset reads as zero.
    logic [31:0]       smem [SCALAR_COUNT];
    logic [31:0]       vmem [VDEPTH];
    logic [SCALAR_COUNT-1:0] sval_reg;
    logic [VDEPTH-1:0] vval_reg;

    logic              s_we, s_re, v_we, v_re;
    logic [SIDX_W-1:0] s_waddr, s_raddr_a, s_raddr_b;
    logic [31:0]       s_wdata, v_wdata;
    logic [VADDR_W-1:0] v_waddr, v_raddr_a, v_raddr_b;
    logic [31:0]       sa_q, sb_q, va_q, vb_q;
    logic              sa_v, sb_v, va_v, vb_v;
    logic [31:0]       sa, sb, va, vb;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              halted_reg, halted_next;
    logic [CNT_W-1:0]  loads_reg, loads_next;
    logic [7:0]        ltgt_reg, ltgt_next;
    logic              lvec_reg, lvec_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [31:0]       base_reg, base_next;

    logic              mv_reg, mv_next;
    kind_t             mkind_reg, mkind_next;
    logic [31:0]       maddr_reg, maddr_next;
    logic [31:0]       mdata_reg, mdata_next;
    logic [7:0]        mpidx_reg, mpidx_next;
    logic [PC_W-1:0]   mpc_reg, mpc_next;
    logic              mhalt_reg, mhalt_next;
    logic              mlast_reg, mlast_next;

    logic              out_free, emit;
    kind_t             e_kind;
    logic [31:0]       e_addr, e_data;
    logic [7:0]        e_pidx;
    logic              e_last;

    logic [SIDX_W-1:0] sd, ss1, ss2;
    logic [VIDX_W-1:0] vd, vs1, vs2;
    logic [31:0]       imm, opb, vopb, lane_off;
    logic [LANE_W-1:0] load_lane;
    logic              last_lane;

    assign sd  = item_reg.dest[SIDX_W-1:0];
    assign ss1 = item_reg.src1[SIDX_W-1:0];
    assign ss2 = item_reg.src2[SIDX_W-1:0];
    assign vd  = item_reg.dest[VIDX_W-1:0];
    assign vs1 = item_reg.src1[VIDX_W-1:0];
    assign vs2 = item_reg.src2[VIDX_W-1:0];
    assign imm = {24'd0, item_reg.src2};

    assign sa   = sa_v ? sa_q : 32'd0;
    assign sb   = sb_v ? sb_q : 32'd0;
    assign va   = va_v ? va_q : 32'd0;
    assign vb   = vb_v ? vb_q : 32'd0;
    assign opb  = item_reg.use_imm ? imm : sb;
    assign vopb = item_reg.use_imm ? imm : vb;

    assign lane_off  = {{(30-LANE_W){1'b0}}, lane_reg, 2'b00};
    assign last_lane = (lane_reg == LANE_W'(VECTOR_LANES-1));
    assign load_lane = LANE_W'(CNT_W'(VECTOR_LANES) - loads_reg);

    assign out_free = !mv_reg || m_tready;

    assign div_a = sa;
    assign div_b = opb;

    assign m_tvalid = mv_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {4'd0, mhalt_reg, mpc_reg, mpidx_reg, mdata_reg, maddr_reg};

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        loads_next  = loads_reg;
        ltgt_next   = ltgt_reg;
        lvec_next   = lvec_reg;
        lane_next   = lane_reg;
        base_next   = base_reg;
        q_pop       = 1'b0;
        div_start   = 1'b0;
        s_we        = 1'b0;
        s_waddr     = sd;
        s_wdata     = 32'd0;
        s_re        = 1'b0;
        s_raddr_a   = (item_reg.cls == CLS_STORE) ? sd : ss1;
        s_raddr_b   = ss2;
        v_we        = 1'b0;
        v_waddr     = {vd, lane_reg};
        v_wdata     = 32'd0;
        v_re        = 1'b0;
        v_raddr_a   = {((item_reg.cls == CLS_VSTORE) ? vd : vs1), lane_reg};
        v_raddr_b   = {vs2, lane_reg};
        emit        = 1'b0;
        e_kind      = KIND_STATUS;
        e_addr      = 32'd0;
        e_data      = 32'd0;
        e_pidx      = 8'd0;
        e_last      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next = ST_STATUS;
                lane_next  = '0;
                if (item_reg.is_data)
                begin
                    if (loads_reg != '0)
                    begin
                        if (lvec_reg)
                        begin
                            v_we    = 1'b1;
                            v_waddr = {ltgt_reg[VIDX_W-1:0], load_lane};
                            v_wdata = item_reg.load_data;
                        end
                        else
                        begin
                            s_we    = 1'b1;
                            s_waddr = ltgt_reg[SIDX_W-1:0];
                            s_wdata = item_reg.load_data;
                        end
                        loads_next = loads_reg - 1'b1;
                    end
                end
                else if (halted_reg || loads_reg != '0)
                begin
                    state_next = ST_STATUS;
                end
                else if (pc_reg[PC_W-1] || pc_reg >= PC_W'(PROGRAM_BYTES))
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + PC_W'(4);
                    unique case (item_reg.cls)
                        CLS_HALT:
                        begin
                            halted_next = 1'b1;
                        end
                        CLS_BRANCH:
                        begin
                            pc_next = pc_reg + PC_W'({{3{item_reg.src2[7]}},
                                                      item_reg.src2, 2'b00});
                        end
                        CLS_NOP:
                        begin
                            state_next = ST_STATUS;
                        end
                        default:
                        begin
                            s_re       = 1'b1;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                state_next = ST_STATUS;
                case (item_reg.cls)
                    CLS_ALU:
                    begin
                        s_we    = 1'b1;
                        s_wdata = alu_op(item_reg.alu_sel, sa, opb);
                    end
                    CLS_DIV:
                    begin
                        if (opb != 32'd0)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    CLS_MOVE:
                    begin
                        s_we    = 1'b1;
                        s_wdata = opb;
                    end
                    CLS_LOAD:
                    begin
                        e_kind = KIND_READ;
                        e_addr = opb;
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            loads_next = CNT_W'(1);
                            ltgt_next  = item_reg.dest;
                            lvec_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    CLS_STORE:
                    begin
                        e_kind = KIND_WRITE;
                        e_addr = opb;
                        e_data = sa;
                        emit   = out_free;
                        if (!out_free)
                        begin
                            state_next = ST_READ;
                        end
                    end
                    CLS_PRINT:
                    begin
                        e_kind = KIND_PRINT;
                        e_data = sb;
                        e_pidx = 8'(ss2);
                        emit   = out_free;
                        if (!out_free)
                        begin
                            state_next = ST_READ;
                        end
                    end
                    CLS_VLOAD:
                    begin
                        base_next  = opb;
                        loads_next = CNT_W'(VECTOR_LANES);
                        ltgt_next  = 8'(vd);
                        lvec_next  = 1'b1;
                        state_next = ST_LREQ;
                    end
                    CLS_VALU, CLS_VSTORE:
                    begin
                        base_next  = opb;
                        state_next = ST_VRD;
                    end
                    default:
                    begin
                        state_next = ST_STATUS;
                    end
                endcase
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    s_we       = 1'b1;
                    s_wdata    = div_q;
                    state_next = ST_STATUS;
                end
            end

            ST_LREQ:
            begin
                e_kind = KIND_READ;
                e_addr = base_reg + lane_off;
                if (out_free)
                begin
                    emit      = 1'b1;
                    lane_next = lane_reg + 1'b1;
                    if (last_lane)
                    begin
                        state_next = ST_STATUS;
                    end
                end
            end

            ST_VRD:
            begin
                v_re       = 1'b1;
                state_next = ST_VEX;
            end

            ST_VEX:
            begin
                e_kind = KIND_WRITE;
                e_addr = base_reg + lane_off;
                e_data = va;
                if (item_reg.cls == CLS_VALU || out_free)
                begin
                    if (item_reg.cls == CLS_VALU)
                    begin
                        v_we    = 1'b1;
                        v_wdata = alu_op(item_reg.alu_sel, va, vopb);
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                    lane_next  = lane_reg + 1'b1;
                    state_next = last_lane ? ST_STATUS : ST_VRD;
                end
            end

            ST_STATUS:
            begin
                e_kind = KIND_STATUS;
                e_last = 1'b1;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register; it takes a new word whenever the old one is gone or taken.
    always_comb
    begin
        mv_next    = mv_reg;
        mkind_next = mkind_reg;
        maddr_next = maddr_reg;
        mdata_next = mdata_reg;
        mpidx_next = mpidx_reg;
        mpc_next   = mpc_reg;
        mhalt_next = mhalt_reg;
        mlast_next = mlast_reg;
        if (emit)
        begin
            mv_next    = 1'b1;
            mkind_next = e_kind;
            maddr_next = e_addr;
            mdata_next = e_data;
            mpidx_next = e_pidx;
            mpc_next   = pc_reg;
            mhalt_next = halted_reg;
            mlast_next = e_last;
        end
        else if (m_tready)
        begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            halted_reg <= 1'b0;
            loads_reg  <= '0;
            ltgt_reg   <= '0;
            lvec_reg   <= 1'b0;
            lane_reg   <= '0;
            mv_reg     <= 1'b0;
            sval_reg   <= '0;
            vval_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
            loads_reg  <= loads_next;
            ltgt_reg   <= ltgt_next;
            lvec_reg   <= lvec_next;
            lane_reg   <= lane_next;
            mv_reg     <= mv_next;
            if (s_we)
            begin
                sval_reg[s_waddr] <= 1'b1;
            end
            if (v_we)
            begin
                vval_reg[v_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        base_reg  <= base_next;
        mkind_reg <= mkind_next;
        maddr_reg <= maddr_next;
        mdata_reg <= mdata_next;
        mpidx_reg <= mpidx_next;
        mpc_reg   <= mpc_next;
        mhalt_reg <= mhalt_next;
        mlast_reg <= mlast_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            sa_q <= smem[s_raddr_a];
            sb_q <= smem[s_raddr_b];
            sa_v <= sval_reg[s_raddr_a];
            sb_v <= sval_reg[s_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            va_q <= vmem[v_raddr_a];
            vb_q <= vmem[v_raddr_b];
            va_v <= vval_reg[v_raddr_a];
            vb_v <= vval_reg[v_raddr_b];
        end
    end

endmodule

>>> hw/rtl/scalar_vector_instruction_executor_top.sv
// A scalar word that reads registers passes the dispatch, read and status states; a divide
// also waits in the divide state, and vector words work through their lanes in turn. The
// sequencer takes one word at a time; load data words pass the dispatch and status states.
// A two-entry queue lets the input side run ahead.
// Reset (rst_n low, asynchronous) clears pc, halt, pending loads and all register valid
// bits, so every scalar and vector register reads as zero right after reset.
module scalar_vector_instruction_executor_top
    import svie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // opcode, dest_index, first_source, second_source, load_data
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // address, data, print_index, next_pc, halted, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic        push, q_full, q_valid, q_pop;
    item_t       push_item, q_item;
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q;

    svie_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    svie_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    svie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    svie_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_a     (div_a),
        .div_b     (div_b),
        .div_done  (div_done),
        .div_q     (div_q),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> dv/svie_tb_pkg.sv
// Opcode and item-type constants shared by the executor testbench files.
package svie_tb_pkg;

    localparam logic ITEM_INSTR = 1'b0;
    localparam logic ITEM_LOAD_DATA = 1'b1;

    localparam logic [7:0] OPC_ADD     = 8'h01;
    localparam logic [7:0] OPC_SUB     = 8'h02;
    localparam logic [7:0] OPC_MUL     = 8'h03;
    localparam logic [7:0] OPC_DIV     = 8'h04;
    localparam logic [7:0] OPC_LD      = 8'h05;
    localparam logic [7:0] OPC_ST      = 8'h06;
    localparam logic [7:0] OPC_MOV     = 8'h07;
    localparam logic [7:0] OPC_PRINT   = 8'h08;
    localparam logic [7:0] OPC_ADDI    = 8'h09;
    localparam logic [7:0] OPC_SUBI    = 8'h0A;
    localparam logic [7:0] OPC_MULI    = 8'h0B;
    localparam logic [7:0] OPC_DIVI    = 8'h0C;
    localparam logic [7:0] OPC_LDI     = 8'h0D;
    localparam logic [7:0] OPC_STI     = 8'h0E;
    localparam logic [7:0] OPC_MOVI    = 8'h0F;
    localparam logic [7:0] OPC_BR      = 8'h10;
    localparam logic [7:0] OPC_BR2     = 8'h1E;
    localparam logic [7:0] OPC_VADD    = 8'h21;
    localparam logic [7:0] OPC_VSUB    = 8'h22;
    localparam logic [7:0] OPC_VMUL    = 8'h23;
    localparam logic [7:0] OPC_VLD     = 8'h25;
    localparam logic [7:0] OPC_VST     = 8'h26;
    localparam logic [7:0] OPC_VADDI   = 8'h29;
    localparam logic [7:0] OPC_VSUBI   = 8'h2A;
    localparam logic [7:0] OPC_VMULI   = 8'h2B;
    localparam logic [7:0] OPC_VLDI    = 8'h2C;
    localparam logic [7:0] OPC_VSTI    = 8'h2E;
    localparam logic [7:0] OPC_UNKNOWN = 8'hFF;

endpackage

>>> dv/svie_checker.sv
// Checker that predicts the executor's result words and compares them as they leave.
module svie_checker
    import svie_pkg::*;
    import svie_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          words_waiting
);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] data;
        logic [7:0]  print_index;
        logic [10:0] next_pc;
        logic        halted;
        logic        last;
    } result_t;

    result_t     expected_words[$];
    logic [31:0] sreg[SCALAR_COUNT];
    logic [31:0] vreg[VECTOR_COUNT][VECTOR_LANES];
    logic [10:0] pc;
    logic        halt;
    int          pending;
    logic [7:0]  ld_dest;
    logic        ld_vec;

    assign words_waiting = expected_words.size();

    function automatic logic [31:0] lane_op(logic [1:0] sel, logic [31:0] a, logic [31:0] b);
        if (sel == 2'd0) return a + b;
        if (sel == 2'd1) return a - b;
        return a * b;
    endfunction

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    task automatic push(kind_t k, logic [31:0] a, logic [31:0] d, logic [7:0] p, logic l);
        result_t r;
        r.kind = k;
        r.address = a;
        r.data = d;
        r.print_index = p;
        r.next_pc = pc;
        r.halted = halt;
        r.last = l;
        expected_words.push_back(r);
    endtask

    task automatic execute(logic op, logic [7:0] opc, logic [7:0] d, logic [7:0] s1,
                           logic [7:0] s2, logic [31:0] ld);
        logic [31:0] base;
        logic [31:0] off;
        logic [10:0] old_pc;
        logic [4:0]  vd;
        logic [4:0]  vs1;
        logic [4:0]  vs2;
        vd = d[4:0];
        vs1 = s1[4:0];
        vs2 = s2[4:0];
        if (op == ITEM_LOAD_DATA) begin
            if (pending != 0) begin
                if (ld_vec)
                    vreg[ld_dest[4:0]][VECTOR_LANES - pending] = ld;
                else
                    sreg[ld_dest] = ld;
                pending--;
            end
            push(KIND_STATUS, 0, 0, 0, 1'b1);
            return;
        end
        if (halt || pending != 0) begin
            push(KIND_STATUS, 0, 0, 0, 1'b1);
            return;
        end
        if (pc[10] || pc >= PROGRAM_BYTES) begin
            halt = 1'b1;
            push(KIND_STATUS, 0, 0, 0, 1'b1);
            return;
        end
        old_pc = pc;
        pc = old_pc + 11'd4;
        if (opc == OPC_HALT) begin
            halt = 1'b1;
            push(KIND_STATUS, 0, 0, 0, 1'b1);
            return;
        end
        if (opc == OPC_BR || opc == OPC_BR2) begin
            off = {{24{s2[7]}}, s2};
            pc = old_pc + 11'(off * 4);
        end
        case (opc)
            OPC_ADD, OPC_SUB, OPC_MUL:
                sreg[d] = lane_op(2'(opc - OPC_ADD), sreg[s1], sreg[s2]);
            OPC_DIV:
                if (sreg[s2] != 0) sreg[d] = signed_quotient(sreg[s1], sreg[s2]);
            OPC_ADDI, OPC_SUBI, OPC_MULI:
                sreg[d] = lane_op(2'(opc - OPC_ADDI), sreg[s1], {24'd0, s2});
            OPC_DIVI:
                if (s2 != 0) sreg[d] = signed_quotient(sreg[s1], {24'd0, s2});
            OPC_LD, OPC_LDI: begin
                base = (opc == OPC_LD) ? sreg[s2] : {24'd0, s2};
                pending = 1;
                ld_dest = d;
                ld_vec = 1'b0;
                push(KIND_READ, base, 0, 0, 1'b0);
            end
            OPC_ST, OPC_STI: begin
                base = (opc == OPC_ST) ? sreg[s2] : {24'd0, s2};
                push(KIND_WRITE, base, sreg[d], 0, 1'b0);
            end
            OPC_MOV: sreg[d] = sreg[s2];
            OPC_MOVI: sreg[d] = {24'd0, s2};
            OPC_PRINT: push(KIND_PRINT, 0, sreg[s2], s2, 1'b0);
            OPC_VADD, OPC_VSUB, OPC_VMUL:
                for (int i = 0; i < VECTOR_LANES; i++)
                    vreg[vd][i] = lane_op(2'(opc - OPC_VADD), vreg[vs1][i], vreg[vs2][i]);
            OPC_VADDI, OPC_VSUBI, OPC_VMULI:
                for (int i = 0; i < VECTOR_LANES; i++)
                    vreg[vd][i] = lane_op(2'(opc - OPC_VADDI), vreg[vs1][i], {24'd0, s2});
            OPC_VLD, OPC_VLDI: begin
                base = (opc == OPC_VLD) ? sreg[s2] : {24'd0, s2};
                pending = VECTOR_LANES;
                ld_dest = d;
                ld_vec = 1'b1;
                for (int i = 0; i < VECTOR_LANES; i++)
                    push(KIND_READ, base + 32'(i * 4), 0, 0, 1'b0);
            end
            OPC_VST, OPC_VSTI: begin
                base = (opc == OPC_VST) ? sreg[s2] : {24'd0, s2};
                for (int i = 0; i < VECTOR_LANES; i++)
                    push(KIND_WRITE, base + 32'(i * 4), vreg[vd][i], 0, 1'b0);
            end
            default: ;
        endcase
        push(KIND_STATUS, 0, 0, 0, 1'b1);
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pc = '0;
        halt = 1'b0;
        pending = 0;
        ld_dest = '0;
        ld_vec = 1'b0;
        foreach (sreg[i]) sreg[i] = '0;
        foreach (vreg[i, j]) vreg[i][j] = '0;
    end

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && s_tvalid && s_tready)
            execute(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24],
                    s_tdata[63:32]);
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", m_tdata[31:0], 0);
            end else begin
                w = expected_words.pop_front();
                if (m_tuser != w.kind) report("kind", m_tuser, w.kind);
                if (m_tdata[31:0] != w.address) report("address", m_tdata[31:0], w.address);
                if (m_tdata[63:32] != w.data) report("data", m_tdata[63:32], w.data);
                if (m_tdata[71:64] != w.print_index)
                    report("print_index", m_tdata[71:64], w.print_index);
                if (m_tdata[82:72] != w.next_pc) report("next_pc", m_tdata[82:72], w.next_pc);
                if (m_tdata[83] != w.halted) report("halted", m_tdata[83], w.halted);
                if (m_tlast != w.last) report("last", m_tlast, w.last);
            end
        end
    end

endmodule

>>> dv/scalar_vector_instruction_executor_top_tb.sv
// Top of the executor testbench: clock, reset, stimulus, output stalls and verdict.
module scalar_vector_instruction_executor_top_tb;
    import svie_pkg::*;
    import svie_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          words_waiting;

    logic [10:0] pc_shadow;
    int          loads_due;
    int          stall_left;
    logic        burst;

    localparam logic [7:0] OPC_MENU[27] = '{OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_LD, OPC_ST,
        OPC_MOV, OPC_PRINT, OPC_ADDI, OPC_SUBI, OPC_MULI, OPC_DIVI, OPC_LDI, OPC_STI, OPC_MOVI,
        OPC_BR, OPC_BR2, OPC_VADD, OPC_VSUB, OPC_VMUL, OPC_VLD, OPC_VST, OPC_VADDI, OPC_VSUBI,
        OPC_VMULI, OPC_VLDI, OPC_VSTI};

    scalar_vector_instruction_executor_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    svie_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_waiting (words_waiting)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: after each accepted word, draw a random stall (none in burst mode) with ready held low.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            gap = burst ? 0 : $urandom_range(0, 12);
            stall_left <= (gap > 0) ? gap - 1 : 0;
            m_tready <= (gap == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(logic op, logic [31:0] bytes, logic [31:0] ld);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ld, bytes};
        s_tuser <= op;
        forever begin
            @(negedge clk);
            if (s_tready) break;
        end
        @(posedge clk);
    endtask

    // Tracks the program counter and pending loads so the program keeps running.
    task automatic issue(logic [7:0] opc, logic [7:0] d, logic [7:0] s1, logic [7:0] s2);
        if (loads_due == 0) begin
            if (opc == OPC_BR || opc == OPC_BR2)
                pc_shadow = pc_shadow + 11'({{24{s2[7]}}, s2} * 4);
            else
                pc_shadow = pc_shadow + 11'd4;
            if (opc == OPC_LD || opc == OPC_LDI) loads_due = 1;
            if (opc == OPC_VLD || opc == OPC_VLDI) loads_due = VECTOR_LANES;
        end
        send_word(ITEM_INSTR, {s2, s1, d, opc}, $urandom());
    endtask

    task automatic return_load(logic [31:0] w);
        if (loads_due > 0) loads_due--;
        send_word(ITEM_LOAD_DATA, $urandom(), w);
    endtask

    function automatic logic [7:0] reg_pick();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15));
    endfunction

    initial
    begin
        logic [7:0] opc;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ITEM_INSTR;
        pc_shadow = '0;
        loads_due = 0;
        burst = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: operand extremes, wraparound, zero divisor, MIN / -1, indices mod 32.
        issue(OPC_MOVI, 8'd1, 8'd0, 8'd255);
        issue(OPC_LDI, 8'd2, 8'd0, 8'd255);
        return_load(32'h8000_0000);
        issue(OPC_LD, 8'd3, 8'd0, 8'd1);
        return_load(32'hFFFF_FFFF);
        issue(OPC_DIV, 8'd4, 8'd2, 8'd3);
        issue(OPC_DIV, 8'd5, 8'd1, 8'd200);
        issue(OPC_ADD, 8'd6, 8'd2, 8'd2);
        issue(OPC_SUB, 8'd7, 8'd2, 8'd1);
        issue(OPC_MUL, 8'd8, 8'd3, 8'd2);
        issue(OPC_DIVI, 8'd9, 8'd1, 8'd0);
        issue(OPC_PRINT, 8'd0, 8'd0, 8'd255);
        issue(OPC_VLDI, 8'd255, 8'd0, 8'd128);
        issue(OPC_ADD, 8'd10, 8'd1, 8'd1);
        for (int i = 0; i < VECTOR_LANES; i++) return_load(i[0] ? 32'hFFFF_FFFF : 32'h7FFF_FFFF);
        return_load(32'h1234_5678);
        issue(OPC_VADD, 8'd1, 8'd31, 8'd255);
        issue(OPC_VSTI, 8'd33, 8'd0, 8'd252);
        issue(OPC_UNKNOWN, 8'd0, 8'd0, 8'd0);
        issue(OPC_BR, 8'd0, 8'd0, 8'd1);
        issue(OPC_BR2, 8'd0, 8'd0, 8'd255);

        for (int n = 0; n < 200; n++) begin
            if (n % 40 == 20) burst = 1'b1;
            if (n % 40 == 35) burst = 1'b0;
            if (loads_due > 0) begin
                if ($urandom_range(0, 7) == 0)
                    issue(OPC_MENU[$urandom_range(0, 26)], reg_pick(), reg_pick(), reg_pick());
                else
                    return_load($urandom());
            end else if (pc_shadow >= 11'd232) begin
                issue(OPC_BR, reg_pick(), reg_pick(), 8'(-(pc_shadow >> 2)));
            end else if ($urandom_range(0, 19) == 0) begin
                return_load($urandom());
            end else begin
                opc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                  : OPC_MENU[$urandom_range(0, 26)];
                if (opc == OPC_BR || opc == OPC_BR2)
                    issue(opc, reg_pick(), reg_pick(), 8'($urandom_range(0, 4)));
                else
                    issue(opc, reg_pick(), reg_pick(), 8'($urandom()));
            end
        end
        burst = 1'b0;
        while (loads_due > 0) return_load($urandom());

        // A branch far back wraps the pc out of range; the next word halts the core.
        issue(OPC_BR, 8'd0, 8'd0, 8'h80);
        issue(OPC_ADD, 8'd1, 8'd1, 8'd1);
        issue(OPC_HALT, 8'd0, 8'd0, 8'd0);
        return_load(32'hDEAD_BEEF);
        s_tvalid <= 1'b0;

        while (words_waiting != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(12 * 600000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
